// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define CHECK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/r2p_pkg.sv
// Shared constants, arctangent table and control word type for the polar converter.
package r2p_pkg;

   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int ANGLE_WIDTH_DEF  = 16;
   localparam int GUARD_BITS       = 16;
   localparam int CORDIC_ITERS     = 28;
   localparam int ZW               = 32;

   localparam logic [ZW-1:0] Z_HALF_TURN = 32'h8000_0000;

   localparam logic [ZW-1:0] ATAN_TABLE [CORDIC_ITERS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005
   };

   typedef struct packed {
      logic last;
      logic phase_on;
      logic zero;
   } ctl_type;

endpackage

// File: hdl/r2p_stage.sv
// One pipeline stage: one square-root result bit and one vectoring rotation; each part passes through past its range.
module r2p_stage
   import r2p_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int STAGE        = 0
)
(
   input  logic                                         clock,
   input  logic                                         load,
   input  logic [2*SAMPLE_WIDTH-1:0]                    up_rem,
   input  logic [SAMPLE_WIDTH-1:0]                      up_root,
   input  logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0]    up_x,
   input  logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0]    up_y,
   input  logic [ZW-1:0]                                up_z,
   input  ctl_type                                      up_ctl,
   output logic [2*SAMPLE_WIDTH-1:0]                    dn_rem,
   output logic [SAMPLE_WIDTH-1:0]                      dn_root,
   output logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0]    dn_x,
   output logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0]    dn_y,
   output logic [ZW-1:0]                                dn_z,
   output ctl_type                                      dn_ctl
);

   localparam int CW = SAMPLE_WIDTH + GUARD_BITS + 3;
   localparam int RW = 2 * SAMPLE_WIDTH;

   logic [RW-1:0]           rem_in, rem_ff;
   logic [SAMPLE_WIDTH-1:0] root_in, root_ff;
   logic signed [CW-1:0]    x_in, x_ff, y_in, y_ff;
   logic [ZW-1:0]           z_in, z_ff;
   ctl_type                 ctl_ff;

   generate
      if (STAGE < SAMPLE_WIDTH) begin : g_sqrt
         localparam int B = SAMPLE_WIDTH - 1 - STAGE;
         logic [RW:0] cand;
         logic [RW:0] rem_ext;
         logic [RW:0] rem_diff;
         always_comb begin
            cand     = ((RW+1)'(up_root) << (B + 1)) | ((RW+1)'(1) << (2 * B));
            rem_ext  = {1'b0, up_rem};
            rem_diff = rem_ext - cand;
            if (rem_ext >= cand) begin
               rem_in  = rem_diff[RW-1:0];
               root_in = up_root | (SAMPLE_WIDTH'(1) << B);
            end else begin
               rem_in  = up_rem;
               root_in = up_root;
            end
         end
      end else begin : g_sqrt_pass
         assign rem_in  = up_rem;
         assign root_in = up_root;
      end

      if (STAGE < CORDIC_ITERS) begin : g_rot
         logic signed [CW-1:0] dx;
         logic signed [CW-1:0] dy;
         always_comb begin
            dx = up_x >>> STAGE;
            dy = up_y >>> STAGE;
            if (!up_y[CW-1]) begin
               x_in = up_x + dy;
               y_in = up_y - dx;
               z_in = up_z + ATAN_TABLE[STAGE];
            end else begin
               x_in = up_x - dy;
               y_in = up_y + dx;
               z_in = up_z - ATAN_TABLE[STAGE];
            end
         end
      end else begin : g_rot_pass
         assign x_in = up_x;
         assign y_in = up_y;
         assign z_in = up_z;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         ctl_ff  <= up_ctl;
      end
   end

   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;
   assign dn_x    = x_ff;
   assign dn_y    = y_ff;
   assign dn_z    = z_ff;
   assign dn_ctl  = ctl_ff;

endmodule

// File: hdl/rect_to_polar_spectrum_unit.sv
// Top level: complex bin to magnitude and phase, fully pipelined.
//
//   channel   direction  handshake              words
//   req_      in         req_valid / req_stall  real_part, imag_part, last_bin
//   rsp_      out        rsp_valid / rsp_stall  magnitude, phase, last_out
//   csr_      in         csr_write_enable       phase_enable
//
// One word per cycle sustained while rsp_stall is low; words pass the front, sum, NS stage and output registers.
// The depth is set by the longer of the square-root bit chain and the 28 rotations.
// Reset (synchronous) empties the pipeline and sets phase_enable to 1.
// Stalls back up stage by stage; empty stages keep filling while the output waits.
`include "assert_macros.svh"
module rect_to_polar_spectrum_unit
   import r2p_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic                           csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_real_part,
   input  logic signed [SAMPLE_WIDTH-1:0] req_imag_part,
   input  logic                           req_last_bin,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [SAMPLE_WIDTH-1:0]        rsp_magnitude,
   output logic signed [ANGLE_WIDTH-1:0]  rsp_phase,
   output logic                           rsp_last_out
);

   localparam int CW = SAMPLE_WIDTH + GUARD_BITS + 3;
   localparam int RW = 2 * SAMPLE_WIDTH;
   localparam int NS = (SAMPLE_WIDTH > CORDIC_ITERS) ? SAMPLE_WIDTH : CORDIC_ITERS;
   localparam int NV = NS + 2;
   localparam int SH = ZW - ANGLE_WIDTH;

   logic phase_enable_ff;

   logic [NV-1:0] stage_valid_ff;
   logic [NV-1:0] stage_valid_in;
   logic [NV-1:0] stage_load;
   logic          rsp_valid_ff;
   logic          out_load;

   // front stage: squares and half-turn pre-rotation
   logic signed [RW-1:0]  re_sq_w, im_sq_w;
   logic signed [CW-1:0]  re_w, im_w, x0_in, y0_in;
   logic [RW-2:0]         sq_re_ff, sq_im_ff;
   logic signed [CW-1:0]  x0_ff, y0_ff;
   logic [ZW-1:0]         z0_in, z0_ff;
   ctl_type               ctl0_in, ctl0_ff;

   // sum stage
   logic [RW-1:0]         sum_in, sum_ff;
   logic signed [CW-1:0]  x1_ff, y1_ff;
   logic [ZW-1:0]         z1_ff;
   ctl_type               ctl1_ff;

   logic [RW-1:0]           st_rem  [0:NS];
   logic [SAMPLE_WIDTH-1:0] st_root [0:NS];
   logic signed [CW-1:0]    st_x    [0:NS];
   logic signed [CW-1:0]    st_y    [0:NS];
   logic [ZW-1:0]           st_z    [0:NS];
   ctl_type                 st_ctl  [0:NS];

   logic [SAMPLE_WIDTH-1:0]        mag_in, mag_ff;
   logic [ZW-1:0]                  z_round;
   logic signed [ANGLE_WIDTH-1:0]  phase_in, phase_ff;
   logic                           last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_enable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         phase_enable_ff <= csr_write_data;
      end
   end

   // advance chain: a stage loads when empty or when its successor loads
   assign out_load = !rsp_valid_ff || !rsp_stall;

   generate
      for (genvar k = 0; k < NV; k++) begin : g_ctl
         if (k == NV - 1) begin : g_tail
            assign stage_load[k] = !stage_valid_ff[k] || out_load;
         end else begin : g_body
            assign stage_load[k] = !stage_valid_ff[k] || stage_load[k+1];
         end
         if (k == 0) begin : g_head
            assign stage_valid_in[k] = req_valid;
         end else begin : g_link
            assign stage_valid_in[k] = stage_valid_ff[k-1];
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               stage_valid_ff[k] <= 1'b0;
            end else if (stage_load[k]) begin
               stage_valid_ff[k] <= stage_valid_in[k];
            end
         end
      end
   endgenerate

   assign req_stall = !stage_load[0];

   always_comb begin
      re_sq_w = RW'(req_real_part) * RW'(req_real_part);
      im_sq_w = RW'(req_imag_part) * RW'(req_imag_part);
      re_w    = CW'(req_real_part) <<< GUARD_BITS;
      im_w    = CW'(req_imag_part) <<< GUARD_BITS;
      if (req_real_part[SAMPLE_WIDTH-1]) begin
         x0_in = -re_w;
         y0_in = -im_w;
         z0_in = Z_HALF_TURN;
      end else begin
         x0_in = re_w;
         y0_in = im_w;
         z0_in = '0;
      end
      ctl0_in.last     = req_last_bin;
      ctl0_in.phase_on = phase_enable_ff;
      ctl0_in.zero     = (req_real_part == '0) && (req_imag_part == '0);
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         sq_re_ff <= re_sq_w[RW-2:0];
         sq_im_ff <= im_sq_w[RW-2:0];
         x0_ff    <= x0_in;
         y0_ff    <= y0_in;
         z0_ff    <= z0_in;
         ctl0_ff  <= ctl0_in;
      end
   end

   assign sum_in = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};

   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         sum_ff  <= sum_in;
         x1_ff   <= x0_ff;
         y1_ff   <= y0_ff;
         z1_ff   <= z0_ff;
         ctl1_ff <= ctl0_ff;
      end
   end

   assign st_rem[0]  = sum_ff;
   assign st_root[0] = '0;
   assign st_x[0]    = x1_ff;
   assign st_y[0]    = y1_ff;
   assign st_z[0]    = z1_ff;
   assign st_ctl[0]  = ctl1_ff;

   generate
      for (genvar s = 0; s < NS; s++) begin : g_stage
         r2p_stage #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .STAGE        (s)
         ) u_stage (
            .clock   (clock),
            .load    (stage_load[s+2]),
            .up_rem  (st_rem[s]),
            .up_root (st_root[s]),
            .up_x    (st_x[s]),
            .up_y    (st_y[s]),
            .up_z    (st_z[s]),
            .up_ctl  (st_ctl[s]),
            .dn_rem  (st_rem[s+1]),
            .dn_root (st_root[s+1]),
            .dn_x    (st_x[s+1]),
            .dn_y    (st_y[s+1]),
            .dn_z    (st_z[s+1]),
            .dn_ctl  (st_ctl[s+1])
         );
      end
   endgenerate

   // round magnitude to nearest, round angle half up to the output width
   always_comb begin
      mag_in  = st_root[NS] + SAMPLE_WIDTH'(st_rem[NS] > RW'(st_root[NS]));
      z_round = st_z[NS] + (ZW'(1) << (SH - 1));
      if (st_ctl[NS].phase_on && !st_ctl[NS].zero) begin
         phase_in = z_round[ZW-1 -: ANGLE_WIDTH];
      end else begin
         phase_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= stage_valid_ff[NV-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         mag_ff   <= mag_in;
         phase_ff <= phase_in;
         last_ff  <= st_ctl[NS].last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = mag_ff;
   assign rsp_phase     = phase_ff;
   assign rsp_last_out  = last_ff;

   `CHECK_IMPLY(a_zero_mag_no_phase, clock, reset, rsp_valid_ff && (rsp_magnitude == '0), rsp_phase == '0, "zero magnitude with nonzero phase")
   `CHECK_IMPLY(a_stall_only_when_full, clock, reset, req_stall, rsp_valid_ff && rsp_stall, "input stalled while output not blocked")
   `CHECK_NEXT(a_no_word_from_nothing, clock, reset, !rsp_valid_ff && !stage_valid_ff[NV-1], !rsp_valid_ff, "output word appeared without a source")

endmodule

// File: dv/testbench.sv
// Self-checking bench for the polar converter: random and corner bins vs. a CORDIC predictor.
module testbench
   import r2p_pkg::*;
();

   localparam int SW             = SAMPLE_WIDTH_DEF;
   localparam int AW             = ANGLE_WIDTH_DEF;
   localparam int PIPE_DEPTH     = 31;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      logic [SW-1:0]        magnitude;
      logic signed [AW-1:0] phase;
      logic                 last;
   } polar_word_type;

   class polar_board_type;
      polar_word_type due_words[$];
      logic           phase_on;
      int             errors;

      function new();
         phase_on = 1'b1;
         errors   = 0;
      endfunction

      function logic [SW-1:0] round_root(longint unsigned s);
         longint unsigned r, t;
         int b;
         r = 0;
         for (b = SW; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= s) r = t;
         end
         if (s - r * r > r) r = r + 1;
         return r[SW-1:0];
      endfunction

      function logic [31:0] turn_angle(longint signed re, longint signed im);
         longint signed x, y, dx, dy;
         logic [31:0] z;
         int i;
         x = re * (64'sd1 <<< GUARD_BITS);
         y = im * (64'sd1 <<< GUARD_BITS);
         z = 32'd0;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
         end
         for (i = 0; i < CORDIC_ITERS; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y >= 0) begin
               x = x + dy;
               y = y - dx;
               z = z + ATAN_TABLE[i];
            end else begin
               x = x - dy;
               y = y + dx;
               z = z - ATAN_TABLE[i];
            end
         end
         return z;
      endfunction

      function void note_bin(logic signed [SW-1:0] re, logic signed [SW-1:0] im, logic last);
         longint signed sre, sim;
         longint unsigned are, aim;
         logic [31:0] z;
         polar_word_type w;
         sre = re;
         sim = im;
         are = (sre < 0) ? -sre : sre;
         aim = (sim < 0) ? -sim : sim;
         w.magnitude = round_root(are * are + aim * aim);
         w.phase     = '0;
         if (phase_on && (sre != 0 || sim != 0)) begin
            z = turn_angle(sre, sim) + (32'd1 << (31 - AW));
            w.phase = z[31 -: AW];
         end
         w.last = last;
         due_words.push_back(w);
      endfunction

      function void check_result(logic [SW-1:0] mag, logic signed [AW-1:0] ph, logic last);
         polar_word_type w;
         if (due_words.size() == 0) begin
            $error("result word with nothing pending: magnitude %0d phase %0d", mag, ph);
            errors++;
            return;
         end
         w = due_words.pop_front();
         if (mag !== w.magnitude) begin
            $error("magnitude: expected %0d, actual %0d", w.magnitude, mag);
            errors++;
         end
         if (ph !== w.phase) begin
            $error("phase: expected %0d, actual %0d", w.phase, ph);
            errors++;
         end
         if (last !== w.last) begin
            $error("last_out: expected %0d, actual %0d", w.last, last);
            errors++;
         end
      endfunction

      function int failures();
         if (due_words.size() != 0) begin
            $error("%0d result words never arrived", due_words.size());
            errors++;
         end
         return errors;
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic                  csr_write_data;
   logic                  req_valid;
   logic                  req_stall;
   logic signed [SW-1:0]  req_real_part;
   logic signed [SW-1:0]  req_imag_part;
   logic                  req_last_bin;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [SW-1:0]         rsp_magnitude;
   logic signed [AW-1:0]  rsp_phase;
   logic                  rsp_last_out;

   polar_board_type board;
   int              gap_pct;
   int              stall_pct;
   int              idle_cycles;

   rect_to_polar_spectrum_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_real_part    (req_real_part),
      .req_imag_part    (req_imag_part),
      .req_last_bin     (req_last_bin),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_magnitude    (rsp_magnitude),
      .rsp_phase        (rsp_phase),
      .rsp_last_out     (rsp_last_out)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_magnitude, rsp_phase, rsp_last_out);
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_bin(input logic signed [SW-1:0] re, input logic signed [SW-1:0] im,
                           input logic last);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_real_part <= re;
      req_imag_part <= im;
      req_last_bin  <= last;
      do @(posedge clock); while (req_stall);
      board.note_bin(re, im, last);
   endtask

   // hold the sender until the pipeline is empty
   task automatic drain();
      req_valid <= 1'b0;
      while (board.due_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_phase_enable(input logic value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.phase_on = value;
   endtask

   function automatic logic signed [SW-1:0] pick_sample();
      logic signed [SW-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = SW'($urandom());
         4: v = SW'(int'($urandom_range(0, 32)) - 16);
         5: begin
            case ($urandom_range(0, 4))
               0: v = {1'b0, {(SW-1){1'b1}}};
               1: v = {1'b1, {(SW-1){1'b0}}};
               2: v = -1;
               3: v = 1;
               default: v = 0;
            endcase
         end
         6: begin
            v = SW'(1) <<< $urandom_range(0, SW - 2);
            if ($urandom_range(0, 1)) v = -v;
         end
         7: v = $signed(SW'($urandom())) >>> $urandom_range(0, SW - 2);
         8: begin
            if ($urandom_range(0, 1))
               v = {1'b0, {(SW-1){1'b1}}} - SW'($urandom_range(0, 15));
            else
               v = {1'b1, {(SW-1){1'b0}}} + SW'($urandom_range(0, 15));
         end
         default: v = 0;
      endcase
      return v;
   endfunction

   task automatic send_spectra(input int count);
      int left, frame_len, k;
      logic signed [SW-1:0] re, im;
      logic last;
      left = count;
      while (left > 0) begin
         frame_len = $urandom_range(1, 48);
         if (frame_len > left) frame_len = left;
         for (k = 0; k < frame_len; k++) begin
            re = pick_sample();
            im = pick_sample();
            case ($urandom_range(0, 11))
               0: im = re;
               1: im = -re;
               default: ;
            endcase
            last = (k == frame_len - 1) ^ ($urandom_range(0, 19) == 0);
            send_bin(re, im, last);
         end
         left -= frame_len;
      end
   endtask

   task automatic send_corners();
      logic signed [SW-1:0] pmax, nmax;
      pmax = {1'b0, {(SW-1){1'b1}}};
      nmax = {1'b1, {(SW-1){1'b0}}};
      send_bin(0, 0, 1'b0);
      send_bin(pmax, 0, 1'b0);
      send_bin(nmax, 0, 1'b1);
      send_bin(0, pmax, 1'b0);
      send_bin(0, nmax, 1'b0);
      send_bin(nmax, nmax, 1'b0);
      send_bin(pmax, pmax, 1'b1);
      send_bin(nmax, pmax, 1'b0);
      send_bin(pmax, nmax, 1'b0);
      send_bin(-1, 0, 1'b0);
      send_bin(1, 0, 1'b0);
      send_bin(0, 1, 1'b0);
      send_bin(0, -1, 1'b1);
      send_bin(-1, -1, 1'b0);
      send_bin(1, -1, 1'b0);
      send_bin(-1, 1, 1'b0);
      send_bin(nmax, 1, 1'b0);
      send_bin(nmax, -1, 1'b0);
      send_bin(-24'sd5592405, 24'sd5592405, 1'b0);
      send_bin(24'sd3, 24'sd4, 1'b1);
   endtask

   initial begin
      board = new();
      gap_pct          = 0;
      stall_pct        = 0;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 1'b0;
      req_valid        <= 1'b0;
      req_real_part    <= '0;
      req_imag_part    <= '0;
      req_last_bin     <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_corners();
      drain();
      write_phase_enable(1'b0);
      gap_pct   = 26;
      stall_pct = 81;
      send_spectra(250);
      drain();
      write_phase_enable(1'b1);
      gap_pct   = 81;
      stall_pct = 26;
      send_spectra(500);
      drain();
      gap_pct   = 0;
      stall_pct = 0;
      send_spectra(350);
      drain();
      send_spectra(300);
      drain();
      repeat (PIPE_DEPTH + 8) @(posedge clock);

      if (board.failures() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// File: sim.f
+incdir+hdl
hdl/r2p_pkg.sv
hdl/r2p_stage.sv
hdl/rect_to_polar_spectrum_unit.sv
dv/testbench.sv
